@@ rtl/qvr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

    // Width of the quaternion registers and of the rotated result fields
    localparam int ROT_W = 16;
    localparam int OUT_W = 16;

    // Configuration register map
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_X = 2'd0,
        REG_ROT_Y = 2'd1,
        REG_ROT_Z = 2'd2,
        REG_ROT_W = 2'd3
    } reg_idx_t;

    localparam logic signed [ROT_W-1:0] ROT_W_RESET = 16'sd16384;

endpackage

`default_nettype wire

@@ rtl/qvr_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface qvr_vec_if #(
    parameter int IN_WIDTH = 16
) ();
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] vec_x;
    logic signed [IN_WIDTH-1:0] vec_y;
    logic signed [IN_WIDTH-1:0] vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface qvr_rot_if ();
    logic                            valid;
    logic                            ready;
    logic signed [qvr_pkg::OUT_W-1:0] out_x;
    logic signed [qvr_pkg::OUT_W-1:0] out_y;
    logic signed [qvr_pkg::OUT_W-1:0] out_z;
    logic                            zero_input;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output zero_input, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input zero_input, output ready);
endinterface

`default_nettype wire

@@ rtl/quaternion_vector_rotation.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Rotates one 3-vector per clock by the quaternion held in rot_x..rot_w:
// the input is scaled to unit length (Q2.14 at FRAC_BITS = 14), then
// r = q * (n,0) * conj(q) is formed and its vector part is saturated to 16
// bits. An all-zero input gives a zero result with zero_input set. The block
// takes one transfer per clock; its pipeline depth is set mostly by the
// one-bit-per-stage square root (32 stages) and the restoring dividers
// (FRAC_BITS + 1 stages). The whole pipeline holds while the output
// transfer is stalled. Write the quaternion only while the pipeline is empty.
module quaternion_vector_rotation #(
    parameter int FRAC_BITS = 14,
    parameter int IN_WIDTH  = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire [qvr_pkg::CFG_IDX_W-1:0]         cfg_idx,
    input  wire [qvr_pkg::ROT_W-1:0]             cfg_data,
    qvr_vec_if.sink                              in_ch,
    qvr_rot_if.source                            out_ch
);

    localparam int MAG_W  = 32;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int TST_W  = SQ_W + 2;
    localparam int SQRT_N = 32;
    localparam int DIV_N  = FRAC_BITS + 1;
    localparam int DIV_W  = MAG_W + FRAC_BITS + 1;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int N_W    = FRAC_BITS + 2;
    localparam int RW     = qvr_pkg::ROT_W;
    localparam int P1_W   = N_W + RW;
    localparam int S1_W   = P1_W + 2;
    localparam int T_W    = S1_W - FRAC_BITS + 1;
    localparam int P2_W   = T_W + RW;
    localparam int S2_W   = P2_W + 2;
    localparam int R2_W   = S2_W - FRAC_BITS + 1;
    localparam int OW     = qvr_pkg::OUT_W;
    localparam int LAT    = 49 + DIV_N;

    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [2:0] neg;
    } tag_t;

    // ---------------- configuration ----------------
    logic signed [RW-1:0] rot_reg [0:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0] <= '0;
            rot_reg[1] <= '0;
            rot_reg[2] <= '0;
            rot_reg[3] <= qvr_pkg::ROT_W_RESET;
        end
        else if (cfg_we)
        begin
            unique case (qvr_pkg::reg_idx_t'(cfg_idx))
                qvr_pkg::REG_ROT_X: rot_reg[0] <= $signed(cfg_data);
                qvr_pkg::REG_ROT_Y: rot_reg[1] <= $signed(cfg_data);
                qvr_pkg::REG_ROT_Z: rot_reg[2] <= $signed(cfg_data);
                qvr_pkg::REG_ROT_W: rot_reg[3] <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    tag_t tag_reg [0:LAT-1];
    logic adv;

    assign adv         = !tag_reg[LAT-1].valid || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                tag_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            tag_reg[0].valid <= in_ch.valid;
            tag_reg[0].zero  <= (in_ch.vec_x == '0) && (in_ch.vec_y == '0)
                                && (in_ch.vec_z == '0);
            tag_reg[0].neg   <= {in_ch.vec_z[IN_WIDTH-1], in_ch.vec_y[IN_WIDTH-1],
                                 in_ch.vec_x[IN_WIDTH-1]};
            for (int k = 1; k < LAT; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // ---------------- capture: magnitudes ----------------
    logic signed [MAG_W:0]  in_ext [0:2];
    logic [MAG_W-1:0]       cap_m_reg [0:2];

    assign in_ext[0] = (MAG_W+1)'(in_ch.vec_x);
    assign in_ext[1] = (MAG_W+1)'(in_ch.vec_y);
    assign in_ext[2] = (MAG_W+1)'(in_ch.vec_z);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                cap_m_reg[c] <= in_ext[c][MAG_W] ? MAG_W'(-in_ext[c]) : MAG_W'(in_ext[c]);
            end
        end
    end

    // ---------------- largest magnitude, then normalizing shift ----------------
    logic [MAG_W-1:0] sh_a_reg [0:5];
    logic [MAG_W-1:0] sh_m_reg [0:5][0:2];
    logic [MAG_W-1:0] max01;

    assign max01 = (cap_m_reg[0] > cap_m_reg[1]) ? cap_m_reg[0] : cap_m_reg[1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sh_a_reg[0] <= (max01 > cap_m_reg[2]) ? max01 : cap_m_reg[2];
            for (int c = 0; c < 3; c++)
            begin
                sh_m_reg[0][c] <= cap_m_reg[c];
            end
        end
    end

    genvar gs;
    generate
        for (gs = 1; gs <= 5; gs++)
        begin : g_shift
            localparam int K = 1 << (5 - gs);
            logic take;

            assign take = ((SQ_W'(sh_a_reg[gs-1]) << K) <= (SQ_W'(1) << 31));

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sh_a_reg[gs] <= take ? (sh_a_reg[gs-1] << K) : sh_a_reg[gs-1];
                    for (int c = 0; c < 3; c++)
                    begin
                        sh_m_reg[gs][c] <= take ? (sh_m_reg[gs-1][c] << K)
                                                : sh_m_reg[gs-1][c];
                    end
                end
            end
        end
    endgenerate

    // ---------------- squares and sum ----------------
    logic [SQ_W-1:0]  sq_reg [0:2];
    logic [MAG_W-1:0] sq_m_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sq_reg[c]   <= SQ_W'(sh_m_reg[5][c]) * SQ_W'(sh_m_reg[5][c]);
                sq_m_reg[c] <= sh_m_reg[5][c];
            end
        end
    end

    // Square root: one result bit per stage, remainder form
    logic [SQ_W-1:0]  rt_rem_reg [0:SQRT_N];
    logic [MAG_W-1:0] rt_r_reg   [0:SQRT_N];
    logic [MAG_W-1:0] rt_m_reg   [0:SQRT_N][0:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rt_rem_reg[0] <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            rt_r_reg[0]   <= '0;
            for (int c = 0; c < 3; c++)
            begin
                rt_m_reg[0][c] <= sq_m_reg[c];
            end
        end
    end

    genvar gr;
    generate
        for (gr = 1; gr <= SQRT_N; gr++)
        begin : g_sqrt
            localparam int I = SQRT_N - gr;
            logic [TST_W-1:0] trial;
            logic             fit;

            assign trial = (TST_W'(rt_r_reg[gr-1]) << (I + 1)) + (TST_W'(1) << (2 * I));
            assign fit   = TST_W'(rt_rem_reg[gr-1]) >= trial;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rt_rem_reg[gr] <= fit ? SQ_W'(TST_W'(rt_rem_reg[gr-1]) - trial)
                                          : rt_rem_reg[gr-1];
                    rt_r_reg[gr]   <= fit ? (rt_r_reg[gr-1] | (MAG_W'(1) << I))
                                          : rt_r_reg[gr-1];
                    for (int c = 0; c < 3; c++)
                    begin
                        rt_m_reg[gr][c] <= rt_m_reg[gr-1][c];
                    end
                end
            end
        end
    endgenerate

    // ---------------- divide each magnitude by the length ----------------
    logic [DIV_W-1:0] dv_rem_reg [0:DIV_N][0:2];
    logic [Q_W-1:0]   dv_q_reg   [0:DIV_N][0:2];
    logic [MAG_W-1:0] dv_len_reg [0:DIV_N];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_len_reg[0] <= rt_r_reg[SQRT_N];
            for (int c = 0; c < 3; c++)
            begin
                dv_rem_reg[0][c] <= (DIV_W'(rt_m_reg[SQRT_N][c]) << FRAC_BITS)
                                    + DIV_W'(rt_r_reg[SQRT_N] >> 1);
                dv_q_reg[0][c]   <= '0;
            end
        end
    end

    genvar gd;
    generate
        for (gd = 1; gd <= DIV_N; gd++)
        begin : g_div
            localparam int B = DIV_N - gd;
            logic [DIV_W-1:0] den;

            assign den = DIV_W'(dv_len_reg[gd-1]) << B;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_len_reg[gd] <= dv_len_reg[gd-1];
                    for (int c = 0; c < 3; c++)
                    begin
                        if (dv_rem_reg[gd-1][c] >= den)
                        begin
                            dv_rem_reg[gd][c] <= dv_rem_reg[gd-1][c] - den;
                            dv_q_reg[gd][c]   <= {dv_q_reg[gd-1][c][Q_W-2:0], 1'b1};
                        end
                        else
                        begin
                            dv_rem_reg[gd][c] <= dv_rem_reg[gd-1][c];
                            dv_q_reg[gd][c]   <= {dv_q_reg[gd-1][c][Q_W-2:0], 1'b0};
                        end
                    end
                end
            end
        end
    endgenerate

    // Restore signs; the tag at this point is the one that entered with the item
    localparam int SGN_ST = 2 + 5 + 2 + SQRT_N + DIV_N;
    logic signed [N_W-1:0] n_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                n_reg[c] <= tag_reg[SGN_ST].neg[c] ? -$signed(N_W'(dv_q_reg[DIV_N][c]))
                                                   : $signed(N_W'(dv_q_reg[DIV_N][c]));
            end
        end
    end

    // ---------------- t = (n,0) * conj(q) ----------------
    logic signed [RW-1:0]   qx, qy, qz, qw;
    logic signed [P1_W-1:0] p1_reg [0:3][0:2];
    logic signed [S1_W-1:0] s1_reg [0:3];
    logic signed [T_W-1:0]  t_reg  [0:3];

    assign qx = rot_reg[0];
    assign qy = rot_reg[1];
    assign qz = rot_reg[2];
    assign qw = rot_reg[3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg[0][0] <= P1_W'(n_reg[0] * qw);
            p1_reg[0][1] <= P1_W'(n_reg[1] * qz);
            p1_reg[0][2] <= P1_W'(n_reg[2] * qy);
            p1_reg[1][0] <= P1_W'(n_reg[1] * qw);
            p1_reg[1][1] <= P1_W'(n_reg[2] * qx);
            p1_reg[1][2] <= P1_W'(n_reg[0] * qz);
            p1_reg[2][0] <= P1_W'(n_reg[2] * qw);
            p1_reg[2][1] <= P1_W'(n_reg[0] * qy);
            p1_reg[2][2] <= P1_W'(n_reg[1] * qx);
            p1_reg[3][0] <= P1_W'(n_reg[0] * qx);
            p1_reg[3][1] <= P1_W'(n_reg[1] * qy);
            p1_reg[3][2] <= P1_W'(n_reg[2] * qz);

            for (int k = 0; k < 3; k++)
            begin
                s1_reg[k] <= S1_W'(p1_reg[k][0]) - S1_W'(p1_reg[k][1]) + S1_W'(p1_reg[k][2]);
            end
            s1_reg[3] <= S1_W'(p1_reg[3][0]) + S1_W'(p1_reg[3][1]) + S1_W'(p1_reg[3][2]);
        end
    end

    // Round half away from zero, then drop the fraction bits
    generate
        for (gr = 0; gr < 4; gr++)
        begin : g_resc1
            logic [S1_W:0] mag;
            logic [S1_W:0] rnd;

            assign mag = s1_reg[gr][S1_W-1] ? (S1_W+1)'(-s1_reg[gr]) : (S1_W+1)'(s1_reg[gr]);
            assign rnd = (mag + ((S1_W+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    t_reg[gr] <= s1_reg[gr][S1_W-1] ? -$signed(T_W'(rnd)) : $signed(T_W'(rnd));
                end
            end
        end
    endgenerate

    // ---------------- r = q * t, vector part ----------------
    logic signed [P2_W-1:0] p2_reg [0:2][0:3];
    logic signed [S2_W-1:0] s2_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_reg[0][0] <= P2_W'(qw * t_reg[0]);
            p2_reg[0][1] <= P2_W'(qx * t_reg[3]);
            p2_reg[0][2] <= P2_W'(qy * t_reg[2]);
            p2_reg[0][3] <= P2_W'(qz * t_reg[1]);
            p2_reg[1][0] <= P2_W'(qw * t_reg[1]);
            p2_reg[1][1] <= P2_W'(qy * t_reg[3]);
            p2_reg[1][2] <= P2_W'(qz * t_reg[0]);
            p2_reg[1][3] <= P2_W'(qx * t_reg[2]);
            p2_reg[2][0] <= P2_W'(qw * t_reg[2]);
            p2_reg[2][1] <= P2_W'(qz * t_reg[3]);
            p2_reg[2][2] <= P2_W'(qx * t_reg[1]);
            p2_reg[2][3] <= P2_W'(qy * t_reg[0]);

            for (int k = 0; k < 3; k++)
            begin
                s2_reg[k] <= S2_W'(p2_reg[k][0]) + S2_W'(p2_reg[k][1])
                             + S2_W'(p2_reg[k][2]) - S2_W'(p2_reg[k][3]);
            end
        end
    end

    // ---------------- rescale, saturate, output register ----------------
    logic signed [OW-1:0] res_reg [0:2];

    generate
        for (gr = 0; gr < 3; gr++)
        begin : g_resc2
            logic [S2_W:0]          mag;
            logic [S2_W:0]          rnd;
            logic signed [R2_W-1:0] r;

            assign mag = s2_reg[gr][S2_W-1] ? (S2_W+1)'(-s2_reg[gr]) : (S2_W+1)'(s2_reg[gr]);
            assign rnd = (mag + ((S2_W+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            assign r   = s2_reg[gr][S2_W-1] ? -$signed(R2_W'(rnd)) : $signed(R2_W'(rnd));

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (tag_reg[LAT-2].zero)
                    begin
                        res_reg[gr] <= '0;
                    end
                    else if (r > R2_W'(32767))
                    begin
                        res_reg[gr] <= OW'(32767);
                    end
                    else if (r < -$signed(R2_W'(32768)))
                    begin
                        res_reg[gr] <= OW'(-32768);
                    end
                    else
                    begin
                        res_reg[gr] <= OW'(r);
                    end
                end
            end
        end
    endgenerate

    assign out_ch.valid      = tag_reg[LAT-1].valid;
    assign out_ch.out_x      = res_reg[0];
    assign out_ch.out_y      = res_reg[1];
    assign out_ch.out_z      = res_reg[2];
    assign out_ch.zero_input = tag_reg[LAT-1].zero;

endmodule

`default_nettype wire

@@ tb/quaternion_vector_rotation_tb.sv @@
`timescale 1ns / 1ps

module quaternion_vector_rotation_tb;

    localparam int FRAC = 14;
    localparam int INW = 16;
    localparam int LATENCY = 50 + FRAC;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               zero;
    } rot_result_t;

    class rotation_scoreboard;
        rot_result_t pending[$];
        int mismatches;
        int checked;
        int zero_seen;

        function new();
            mismatches = 0;
            checked = 0;
            zero_seen = 0;
        endfunction

        function void note_vector(rot_result_t r);
            pending.push_back(r);
        endfunction

        function void check_result(rot_result_t got);
            rot_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d z=%0d zero=%0d",
                             got.x, got.y, got.z, got.zero);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.zero)
                zero_seen++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: want %0d %0d %0d z%0d, got %0d %0d %0d z%0d",
                             want.x, want.y, want.z, want.zero,
                             got.x, got.y, got.z, got.zero);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [qvr_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [qvr_pkg::ROT_W-1:0] cfg_data = '0;

    qvr_vec_if #(.IN_WIDTH(INW)) in_ch ();
    qvr_rot_if out_ch ();

    quaternion_vector_rotation #(.FRAC_BITS(FRAC), .IN_WIDTH(INW)) i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always #2 clk = ~clk;

    rotation_scoreboard sb;
    logic signed [15:0] quat[4];
    int stall_cycles = 0;
    int sent = 0;
    bit stim_done = 0;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.vec_x = '0;
        in_ch.vec_y = '0;
        in_ch.vec_z = '0;
        out_ch.ready = 1'b0;
    end

    function automatic longint round_down_frac(longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (FRAC - 1))) >>> FRAC;
        return (v < 0) ? -m : m;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned m);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > m)
            b >>= 2;
        while (b != 0)
        begin
            if (m >= res + b)
            begin
                m -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic rot_result_t rotate_vector(logic signed [15:0] vx,
                                                  logic signed [15:0] vy,
                                                  logic signed [15:0] vz);
        longint v[3];
        longint unsigned m[3];
        longint unsigned a;
        longint unsigned sq;
        longint unsigned len;
        longint unsigned q;
        longint n[3];
        longint qx, qy, qz, qw, tx, ty, tz, tw;
        int s;
        rot_result_t r;
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        a = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            if (m[i] > a)
                a = m[i];
        end
        if (a == 0)
        begin
            r = '{x: '0, y: '0, z: '0, zero: 1'b1};
            return r;
        end
        s = 0;
        while ((a << 1) <= (64'd1 << 31))
        begin
            a <<= 1;
            s++;
        end
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] <<= s;
            sq += m[i] * m[i];
        end
        len = int_sqrt(sq);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FRAC) + (len >> 1)) / len;
            n[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        qx = quat[qvr_pkg::REG_ROT_X];
        qy = quat[qvr_pkg::REG_ROT_Y];
        qz = quat[qvr_pkg::REG_ROT_Z];
        qw = quat[qvr_pkg::REG_ROT_W];
        tx = round_down_frac(n[0] * qw - n[1] * qz + n[2] * qy);
        ty = round_down_frac(n[1] * qw - n[2] * qx + n[0] * qz);
        tz = round_down_frac(n[2] * qw - n[0] * qy + n[1] * qx);
        tw = round_down_frac(n[0] * qx + n[1] * qy + n[2] * qz);
        r.x = clamp16(round_down_frac(qw * tx + qx * tw + qy * tz - qz * ty));
        r.y = clamp16(round_down_frac(qw * ty + qy * tw + qz * tx - qx * tz));
        r.z = clamp16(round_down_frac(qw * tz + qz * tw + qx * ty - qy * tx));
        r.zero = 1'b0;
        return r;
    endfunction

    // Record input transfers and check output transfers.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_vector(rotate_vector(in_ch.vec_x, in_ch.vec_y, in_ch.vec_z));
            if (out_ch.valid && out_ch.ready)
                sb.check_result('{x: out_ch.out_x, y: out_ch.out_y, z: out_ch.out_z,
                                  zero: out_ch.zero_input});
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (stim_done && sb.pending.size() == 0))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Receiver stall pattern: random stretches of full readiness, light stalls or heavy stalls.
    initial
    begin
        int mode;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(10, 80))
            begin
                @(posedge clk);
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic write_quat(qvr_pkg::reg_idx_t idx, logic signed [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        quat[idx] = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_quat(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z, logic signed [15:0] w);
        write_quat(qvr_pkg::REG_ROT_X, x);
        write_quat(qvr_pkg::REG_ROT_Y, y);
        write_quat(qvr_pkg::REG_ROT_Z, z);
        write_quat(qvr_pkg::REG_ROT_W, w);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Hold valid until the transfer happens.
    task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
        in_ch.valid <= 1'b1;
        in_ch.vec_x <= x;
        in_ch.vec_y <= y;
        in_ch.vec_z <= z;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic pause_sender(int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1: return 16'($urandom_range(0, 8) - 4);
            2: return $urandom_range(0, 1) ? 16'sh0000 : 16'sh0001;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int count);
        int burst;
        while (count > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && count > 0)
            begin
                send_vector(rand_field(), rand_field(), rand_field());
                burst--;
                count--;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end
        pause_sender(0);
    endtask

    function automatic logic signed [15:0] rand_quat_part();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        endcase
    endfunction

    initial
    begin
        sb = new();
        quat[qvr_pkg::REG_ROT_X] = 0;
        quat[qvr_pkg::REG_ROT_Y] = 0;
        quat[qvr_pkg::REG_ROT_Z] = 0;
        quat[qvr_pkg::REG_ROT_W] = qvr_pkg::ROT_W_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity after reset: extremes, zero vector, single axes.
        send_vector(16'sh0000, 16'sh0000, 16'sh0000);
        send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_vector(16'sh8000, 16'sh8000, 16'sh8000);
        send_vector(16'sh8000, 16'sh7fff, 16'sh0000);
        send_vector(16'sh0001, 16'sh0000, 16'sh0000);
        send_vector(16'sh0000, -16'sd1, 16'sh0000);
        send_vector(16'sh0000, 16'sh0000, 16'sh0003);
        send_vector(16'sh5555, -16'sd21846, 16'sh00ff);
        pause_sender(0);
        drain();

        // Quarter turn about z, then the unnormalized all-max quaternion for saturation.
        set_quat(16'sd0, 16'sd0, 16'sd11585, 16'sd11585);
        send_vector(16'sd100, 16'sd0, 16'sd0);
        send_vector(16'sd0, 16'sd100, 16'sd0);
        send_vector(16'sh0000, 16'sh0000, 16'sh0000);
        pause_sender(0);
        drain();
        set_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
        send_vector(16'sh7fff, 16'sh0001, 16'sh8000);
        send_vector(16'sd1, 16'sd1, 16'sd1);
        pause_sender(0);
        drain();
        set_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
        send_vector(16'sh8000, 16'sh8000, 16'sh8000);
        send_vector(16'sd5, -16'sd7, 16'sd3);
        pause_sender(0);
        drain();

        // Random phases, each under its own quaternion.
        for (int ph = 0; ph < 6; ph++)
        begin
            set_quat(rand_quat_part(), rand_quat_part(), rand_quat_part(), rand_quat_part());
            random_phase(200);
            drain();
        end

        stim_done = 1;
        drain();
        $display("covered %0d vectors, %0d results checked (%0d zero inputs)",
                 sent, sb.checked, sb.zero_seen);
        $display("quaternion settings: identity, quarter turn, +/-max, six random");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.pending.size());
            $display("tb: failure");
        end
        $finish;
    end
endmodule
